// File: design/mps_pkg.sv
// shared types, codes and reset values for the mission phase sequencer
`default_nettype none

package mps_pkg;

  // mission phases, one-hot
  typedef enum logic [7:0] {
    PH_INIT     = 8'b0000_0001,
    PH_ARMED    = 8'b0000_0010,
    PH_TAKEOFF  = 8'b0000_0100,
    PH_CRUISE   = 8'b0000_1000,
    PH_EXECUTE  = 8'b0001_0000,
    PH_RETURN   = 8'b0010_0000,
    PH_LANDING  = 8'b0100_0000,
    PH_COMPLETE = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_START  = 2'd1,
    CMD_ABORT  = 2'd2
  } cmd_t;

  localparam logic [1:0] CFG_PHASE_TIMEOUT    = 2'd0;
  localparam logic [1:0] CFG_TAKEOFF_ALTITUDE = 2'd1;
  localparam logic [1:0] CFG_HOME_RADIUS      = 2'd2;

  localparam logic [31:0] PHASE_TIMEOUT_RST    = 32'd30000;
  localparam logic [22:0] TAKEOFF_ALTITUDE_RST = 23'd10000;
  localparam logic [22:0] HOME_RADIUS_RST      = 23'd2000;

  // landing ends below this altitude, mm
  localparam logic signed [23:0] LAND_LIMIT_MM = 24'sd500;

  // waypoint counts saturate here
  localparam logic [7:0] MAX_WAYPOINTS = 8'd16;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_INIT:     code = 3'd0;
      PH_ARMED:    code = 3'd1;
      PH_TAKEOFF:  code = 3'd2;
      PH_CRUISE:   code = 3'd3;
      PH_EXECUTE:  code = 3'd4;
      PH_RETURN:   code = 3'd5;
      PH_LANDING:  code = 3'd6;
      PH_COMPLETE: code = 3'd7;
      default:     code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic phase_t phase_succ(phase_t ph);
    phase_t nxt;
    case (ph)
      PH_INIT:     nxt = PH_ARMED;
      PH_ARMED:    nxt = PH_TAKEOFF;
      PH_TAKEOFF:  nxt = PH_CRUISE;
      PH_CRUISE:   nxt = PH_EXECUTE;
      PH_EXECUTE:  nxt = PH_RETURN;
      PH_RETURN:   nxt = PH_LANDING;
      PH_LANDING:  nxt = PH_COMPLETE;
      default:     nxt = PH_COMPLETE;
    endcase
    return nxt;
  endfunction

  function automatic logic [7:0] sat_waypoint(logic [4:0] v);
    logic [7:0] v8;
    v8 = {3'b000, v};
    return (v8 > MAX_WAYPOINTS) ? MAX_WAYPOINTS : v8;
  endfunction

endpackage

`default_nettype wire

// File: design/mission_phase_sequencer.sv
// mission phase sequencer top level: input register, phase logic, result register
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | cmd, time, flags, position, waypoints
//   out_    | output    | out_valid / out_stall  | phase, changed, prior, failsafe, status
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; each item reaches the result register
// (input register, then phase logic with the return-distance squares into the result reg)
// the phase state updates as an item moves into the result register
// rst_n (synchronous) restores register defaults and the init phase, failsafe clear
// a held result stalls the input register, and in_stall rises only while it is full
// cfg_ready is always high; writes are expected only while no item is in flight
`default_nettype none

module mission_phase_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [31:0]        in_now_time,
  input  wire logic               in_armed_flag,
  input  wire logic               in_emergency_flag,
  input  wire logic               in_low_battery_flag,
  input  wire logic               in_comm_lost_flag,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [23:0] in_pos_z,
  input  wire logic [4:0]         in_waypoint_total,
  input  wire logic [4:0]         in_waypoint_index,

  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [2:0]         out_phase,
  output      logic               out_changed,
  output      logic [2:0]         out_prior_phase,
  output      logic               out_failsafe,
  output      logic               out_status,

  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // configuration registers
  logic [31:0] phase_timeout_r;
  logic [22:0] takeoff_alt_r;
  logic [22:0] home_radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_timeout_r <= mps_pkg::PHASE_TIMEOUT_RST;
      takeoff_alt_r   <= mps_pkg::TAKEOFF_ALTITUDE_RST;
      home_radius_r   <= mps_pkg::HOME_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mps_pkg::CFG_PHASE_TIMEOUT:    phase_timeout_r <= cfg_data;
        mps_pkg::CFG_TAKEOFF_ALTITUDE: takeoff_alt_r   <= cfg_data[22:0];
        mps_pkg::CFG_HOME_RADIUS:      home_radius_r   <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               s0_valid_r;
  logic [1:0]         s0_cmd_r;
  logic [31:0]        s0_now_r;
  logic               s0_armed_r;
  logic               s0_alarm_r;
  logic signed [23:0] s0_x_r;
  logic signed [23:0] s0_y_r;
  logic signed [23:0] s0_z_r;
  logic [4:0]         s0_wp_total_r;
  logic [4:0]         s0_wp_index_r;

  logic out_free;
  logic s0_fire;
  logic in_accept;

  assign out_free  = !out_valid || !out_stall;
  assign s0_fire   = s0_valid_r && out_free;
  assign in_stall  = s0_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_accept) begin
      s0_valid_r <= 1'b1;
    end else if (s0_fire) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_cmd_r      <= in_cmd;
      s0_now_r      <= in_now_time;
      s0_armed_r    <= in_armed_flag;
      s0_alarm_r    <= in_emergency_flag || in_low_battery_flag || in_comm_lost_flag;
      s0_x_r        <= in_pos_x;
      s0_y_r        <= in_pos_y;
      s0_z_r        <= in_pos_z;
      s0_wp_total_r <= in_waypoint_total;
      s0_wp_index_r <= in_waypoint_index;
    end
  end

  // sequencer state
  mps_pkg::phase_t phase_r;
  logic [31:0]     phase_start_r;
  logic            failsafe_r;
  logic [31:0]     uptime_r;

  // takeoff test: z*20 >= alt*19
  logic signed [29:0] z20;
  logic signed [29:0] alt19;
  assign z20   = $signed({{6{s0_z_r[23]}}, s0_z_r}) * 30'sd20;
  assign alt19 = $signed({7'b0, takeoff_alt_r}) * 30'sd19;

  // return test: squared distance to home against radius squared
  logic signed [24:0] dz;
  logic signed [24:0] dz_neg;
  logic [23:0]        ax;
  logic [23:0]        ay;
  logic [23:0]        adz;
  logic signed [23:0] x_neg;
  logic signed [23:0] y_neg;
  logic [47:0]        x_sq;
  logic [47:0]        y_sq;
  logic [47:0]        dz_sq;
  logic [45:0]        r_sq;
  logic [49:0]        dist_sq;

  assign dz     = $signed({s0_z_r[23], s0_z_r}) - $signed({2'b00, takeoff_alt_r});
  assign dz_neg = -dz;
  assign x_neg  = -s0_x_r;
  assign y_neg  = -s0_y_r;
  assign ax     = s0_x_r[23] ? x_neg : s0_x_r;
  assign ay     = s0_y_r[23] ? y_neg : s0_y_r;
  assign adz    = dz[24] ? dz_neg[23:0] : dz[23:0];
  assign x_sq   = ax * ax;
  assign y_sq   = ay * ay;
  assign dz_sq  = adz * adz;
  assign r_sq   = home_radius_r * home_radius_r;
  assign dist_sq = {2'b00, x_sq} + {2'b00, y_sq} + {2'b00, dz_sq};

  logic [7:0]  wp_total;
  logic [7:0]  wp_index;
  logic [31:0] elapsed;
  logic        exit_ok;

  assign wp_total = mps_pkg::sat_waypoint(s0_wp_total_r);
  assign wp_index = mps_pkg::sat_waypoint(s0_wp_index_r);
  assign elapsed  = s0_now_r - phase_start_r;

  always_comb begin
    case (phase_r)
      mps_pkg::PH_ARMED:   exit_ok = s0_armed_r;
      mps_pkg::PH_TAKEOFF: exit_ok = z20 >= alt19;
      mps_pkg::PH_CRUISE:  exit_ok = wp_total != 8'd0;
      mps_pkg::PH_EXECUTE: exit_ok = wp_index >= wp_total;
      mps_pkg::PH_RETURN:  exit_ok = dist_sq < {4'b0000, r_sq};
      mps_pkg::PH_LANDING: exit_ok = s0_z_r < mps_pkg::LAND_LIMIT_MM;
      default:             exit_ok = 1'b0;
    endcase
  end

  // next state and result
  mps_pkg::phase_t phase_nxt;
  mps_pkg::phase_t prior_nxt;
  logic [31:0]     phase_start_nxt;
  logic            failsafe_nxt;
  logic [31:0]     uptime_nxt;
  logic            changed_nxt;
  logic            status_nxt;
  logic            trip;

  always_comb begin
    phase_nxt       = phase_r;
    prior_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    failsafe_nxt    = failsafe_r;
    uptime_nxt      = uptime_r;
    changed_nxt     = 1'b0;
    status_nxt      = 1'b0;
    trip            = 1'b0;
    case (s0_cmd_r)
      mps_pkg::CMD_UPDATE: begin
        uptime_nxt = s0_now_r;
        // vehicle alarm in any phase, timeout in all but complete
        trip = !failsafe_r && (s0_alarm_r ||
               (elapsed > phase_timeout_r && phase_r != mps_pkg::PH_COMPLETE));
        if (trip) begin
          failsafe_nxt    = 1'b1;
          phase_nxt       = mps_pkg::PH_RETURN;
          changed_nxt     = 1'b1;
          phase_start_nxt = s0_now_r;
        end else if (!failsafe_r && phase_r != mps_pkg::PH_COMPLETE && exit_ok) begin
          phase_nxt       = mps_pkg::phase_succ(phase_r);
          changed_nxt     = 1'b1;
          phase_start_nxt = s0_now_r;
        end
      end
      mps_pkg::CMD_START: begin
        if (phase_r != mps_pkg::PH_INIT) begin
          status_nxt = 1'b1;
        end else begin
          phase_nxt       = mps_pkg::PH_ARMED;
          changed_nxt     = 1'b1;
          phase_start_nxt = uptime_r;
        end
      end
      mps_pkg::CMD_ABORT: begin
        // return to return still counts as a transition
        phase_nxt       = mps_pkg::PH_RETURN;
        changed_nxt     = 1'b1;
        phase_start_nxt = uptime_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mps_pkg::PH_INIT;
      phase_start_r <= 32'd0;
      failsafe_r    <= 1'b0;
      uptime_r      <= 32'd0;
    end else if (s0_fire) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      failsafe_r    <= failsafe_nxt;
      uptime_r      <= uptime_nxt;
    end
  end

  // result register
  logic       out_valid_r;
  logic [2:0] out_phase_r;
  logic       out_changed_r;
  logic [2:0] out_prior_r;
  logic       out_failsafe_r;
  logic       out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      out_phase_r    <= mps_pkg::phase_code(phase_nxt);
      out_changed_r  <= changed_nxt;
      out_prior_r    <= mps_pkg::phase_code(prior_nxt);
      out_failsafe_r <= failsafe_nxt;
      out_status_r   <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase       = out_phase_r;
  assign out_changed     = out_changed_r;
  assign out_prior_phase = out_prior_r;
  assign out_failsafe    = out_failsafe_r;
  assign out_status      = out_status_r;

  // without a transition the prior phase is the reported phase
  a_no_change_prior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_changed_r |-> out_prior_r == out_phase_r)
    else $error("prior phase differs without a transition");

  // a refused start never moves the phase and never happens in init
  a_refused_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |->
      !out_changed_r && out_phase_r != mps_pkg::phase_code(mps_pkg::PH_INIT))
    else $error("refused start with a transition or from init");

  // failsafe latch only clears on reset
  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    failsafe_r |=> failsafe_r)
    else $error("failsafe latch dropped");

  // state moves only when an item passes into the result register
  a_state_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_fire |=> $stable(phase_r) && $stable(phase_start_r) && $stable(uptime_r))
    else $error("sequencer state changed without an item");

  // a latched failsafe always reports it
  a_report_latch: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && failsafe_r |=> out_failsafe_r)
    else $error("latched failsafe not reported");

endmodule

`default_nettype wire

// File: bench/tb.sv
// testbench for the mission phase sequencer: flight table plus random commands
module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // flag nibble order: armed, emergency, low battery, comm lost
  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_ARMED = 4'b1000;

  typedef enum logic [2:0] {
    P_INIT     = 3'd0,
    P_ARMED    = 3'd1,
    P_TAKEOFF  = 3'd2,
    P_CRUISE   = 3'd3,
    P_EXECUTE  = 3'd4,
    P_RETURN   = 3'd5,
    P_LANDING  = 3'd6,
    P_COMPLETE = 3'd7
  } phase_code_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic        armed;
    logic        emerg;
    logic        lowbat;
    logic        comm;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [4:0]  wp_total;
    logic [4:0]  wp_index;
  } flight_cmd_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       changed;
    logic [2:0] prior;
    logic       failsafe;
    logic       status;
  } phase_report_t;

  typedef struct packed {
    flight_cmd_t   c;
    logic          chk;
    phase_report_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = 2'd0;
  logic [31:0]        in_now_time = 32'd0;
  logic               in_armed_flag = 1'b0;
  logic               in_emergency_flag = 1'b0;
  logic               in_low_battery_flag = 1'b0;
  logic               in_comm_lost_flag = 1'b0;
  logic signed [23:0] in_pos_x = 24'sd0;
  logic signed [23:0] in_pos_y = 24'sd0;
  logic signed [23:0] in_pos_z = 24'sd0;
  logic [4:0]         in_waypoint_total = 5'd0;
  logic [4:0]         in_waypoint_index = 5'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_phase;
  logic               out_changed;
  logic [2:0]         out_prior_phase;
  logic               out_failsafe;
  logic               out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 2'd0;
  logic [31:0]        cfg_data = 32'd0;

  mission_phase_sequencer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_now_time         (in_now_time),
    .in_armed_flag       (in_armed_flag),
    .in_emergency_flag   (in_emergency_flag),
    .in_low_battery_flag (in_low_battery_flag),
    .in_comm_lost_flag   (in_comm_lost_flag),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .in_waypoint_total   (in_waypoint_total),
    .in_waypoint_index   (in_waypoint_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_phase           (out_phase),
    .out_changed         (out_changed),
    .out_prior_phase     (out_prior_phase),
    .out_failsafe        (out_failsafe),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted sequencer state and register copies
  logic [2:0]  ph_now = P_INIT;
  logic [31:0] ph_since = 32'd0;
  logic [31:0] clock_ms = 32'd0;
  logic        fs_on = 1'b0;
  logic [31:0] tmo_ms = mps_pkg::PHASE_TIMEOUT_RST;
  logic [22:0] alt_mm = mps_pkg::TAKEOFF_ALTITUDE_RST;
  logic [22:0] rad_mm = mps_pkg::HOME_RADIUS_RST;
  logic        step_chg;
  logic [2:0]  step_prior;

  phase_report_t report_q[$];
  plan_row_t     flight_plan[$];
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 1;
  int calm_left = 0;

  function automatic int pick_gap();
    return (calm_left != 0) ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic flight_cmd_t fc(logic [1:0] cmd, logic [31:0] now, logic [3:0] flg,
                                     int x, int y, int z, int wt, int wi);
    flight_cmd_t r;
    r.cmd = cmd;
    r.now = now;
    {r.armed, r.emerg, r.lowbat, r.comm} = flg;
    r.x = x[23:0];
    r.y = y[23:0];
    r.z = z[23:0];
    r.wp_total = wt[4:0];
    r.wp_index = wi[4:0];
    return r;
  endfunction

  function automatic phase_report_t pr(logic [2:0] ph, logic chg, logic [2:0] prior,
                                       logic fs, logic st);
    phase_report_t r;
    r.phase = ph;
    r.changed = chg;
    r.prior = prior;
    r.failsafe = fs;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(flight_cmd_t c, logic chk, phase_report_t want);
    plan_row_t r;
    r.c = c;
    r.chk = chk;
    r.want = want;
    flight_plan.push_back(r);
  endtask

  task automatic enter_phase(input logic [2:0] nxt);
    step_prior = ph_now;
    step_chg = 1'b1;
    ph_now = nxt;
    ph_since = clock_ms;
  endtask

  task automatic step_mission(input flight_cmd_t c, output phase_report_t r);
    logic signed [63:0] x, y, z, dz, alt;
    logic [63:0] d2, rr;
    logic [31:0] elapsed;
    logic [7:0] tot, idx;
    logic go;
    step_chg = 1'b0;
    step_prior = ph_now;
    r.status = 1'b0;
    x = 64'($signed(c.x));
    y = 64'($signed(c.y));
    z = 64'($signed(c.z));
    alt = $signed({41'd0, alt_mm});
    tot = ({3'b000, c.wp_total} > mps_pkg::MAX_WAYPOINTS) ? mps_pkg::MAX_WAYPOINTS
                                                           : {3'b000, c.wp_total};
    idx = ({3'b000, c.wp_index} > mps_pkg::MAX_WAYPOINTS) ? mps_pkg::MAX_WAYPOINTS
                                                           : {3'b000, c.wp_index};
    case (c.cmd)
      mps_pkg::CMD_UPDATE: begin
        clock_ms = c.now;
        if (!fs_on) begin
          if (c.emerg || c.lowbat || c.comm) begin
            fs_on = 1'b1;
            enter_phase(P_RETURN);
          end
          elapsed = c.now - ph_since;
          if (elapsed > tmo_ms && ph_now != P_COMPLETE) begin
            fs_on = 1'b1;
            enter_phase(P_RETURN);
          end
        end
        if (!fs_on && ph_now != P_COMPLETE) begin
          case (ph_now)
            P_ARMED:   go = c.armed;
            P_TAKEOFF: go = (z * 20 >= alt * 19);
            P_CRUISE:  go = (tot != 8'd0);
            P_EXECUTE: go = (idx >= tot);
            P_RETURN: begin
              dz = z - alt;
              d2 = x * x + y * y + dz * dz;
              rr = {41'd0, rad_mm} * {41'd0, rad_mm};
              go = (d2 < rr);
            end
            P_LANDING: go = (z < mps_pkg::LAND_LIMIT_MM);
            default:   go = 1'b0;
          endcase
          if (go) enter_phase(ph_now + 3'd1);
        end
      end
      mps_pkg::CMD_START: begin
        if (ph_now != P_INIT) r.status = 1'b1;
        else enter_phase(P_ARMED);
      end
      mps_pkg::CMD_ABORT: enter_phase(P_RETURN);
      default: ;
    endcase
    r.phase = ph_now;
    r.changed = step_chg;
    r.prior = step_prior;
    r.failsafe = fs_on;
  endtask

  task automatic send_item(input flight_cmd_t c, input logic chk, input phase_report_t want);
    int gap;
    phase_report_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= c.cmd;
    in_now_time <= c.now;
    in_armed_flag <= c.armed;
    in_emergency_flag <= c.emerg;
    in_low_battery_flag <= c.lowbat;
    in_comm_lost_flag <= c.comm;
    in_pos_x <= c.x;
    in_pos_y <= c.y;
    in_pos_z <= c.z;
    in_waypoint_total <= c.wp_total;
    in_waypoint_index <= c.wp_index;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_mission(c, p);
    report_q.push_back(chk ? want : p);
    items_sent++;
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
  endtask

  // drain the pipe before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] tmo, input logic [22:0] alt,
                            input logic [22:0] rad);
    logic [31:0] vals[3];
    logic [1:0] regs[3];
    vals[0] = tmo;
    vals[1] = {9'd0, alt};
    vals[2] = {9'd0, rad};
    regs[0] = mps_pkg::CFG_PHASE_TIMEOUT;
    regs[1] = mps_pkg::CFG_TAKEOFF_ALTITUDE;
    regs[2] = mps_pkg::CFG_HOME_RADIUS;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    tmo_ms = tmo;
    alt_mm = alt;
    rad_mm = rad;
    settings_used++;
  endtask

  // random commands shaped around the predicted phase; the tail also trips failsafe
  task automatic run_random(input int count, input logic tail);
    flight_cmd_t c;
    int lim, alt, roll, px, py, pz;
    for (int i = 0; i < count; i++) begin
      lim = int'(rad_mm);
      alt = int'(alt_mm);
      roll = $urandom_range(0, 99);
      if (roll < 78) c.cmd = mps_pkg::CMD_UPDATE;
      else if (roll < 86) c.cmd = mps_pkg::CMD_ABORT;
      else if (roll < 93) c.cmd = mps_pkg::CMD_START;
      else c.cmd = CMD_UNUSED;
      case ($urandom_range(0, 3))
        0: begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end
        1: begin
          // somewhere around home
          px = int'($urandom_range(0, 2 * lim)) - lim;
          py = int'($urandom_range(0, 2 * lim)) - lim;
          pz = alt + int'($urandom_range(0, 2 * lim)) - lim;
        end
        2: begin
          // on the radius or just inside
          px = lim - int'($urandom_range(0, 1));
          py = 0;
          pz = alt;
        end
        default: begin
          px = $urandom;
          py = $urandom;
          pz = 498 + int'($urandom_range(0, 3));
        end
      endcase
      c.x = px[23:0];
      c.y = py[23:0];
      c.z = pz[23:0];
      if (tmo_ms == 32'hFFFF_FFFF) c.now = $urandom;
      else if (tail && $urandom_range(0, 9) == 0)
        c.now = ph_since + tmo_ms + 32'd1 + $urandom_range(0, 1000);
      else if ($urandom_range(0, 3) == 0) c.now = ph_since + tmo_ms;
      else c.now = ph_since + $urandom_range(0, tmo_ms);
      c.armed = 1'($urandom_range(0, 1));
      c.emerg = tail && ($urandom_range(0, 15) == 0);
      c.lowbat = tail && ($urandom_range(0, 15) == 0);
      c.comm = tail && ($urandom_range(0, 15) == 0);
      c.wp_total = 5'($urandom_range(0, 31));
      c.wp_index = 5'($urandom_range(0, 31));
      send_item(c, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    phase_report_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      got = pr(out_phase, out_changed, out_prior_phase, out_failsafe, out_status);
      if (report_q.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d arrived with no item pending: phase %0d", results_seen,
                   out_phase);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display({"result %0d: expected phase %0d chg %0d prior %0d fs %0d st %0d,",
                      " got phase %0d chg %0d prior %0d fs %0d st %0d"},
                     results_seen, want.phase, want.changed, want.prior, want.failsafe,
                     want.status, got.phase, got.changed, got.prior, got.failsafe,
                     got.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    add_row(fc(mps_pkg::CMD_UPDATE, 100, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_INIT, 1'b0, P_INIT, 1'b0, 1'b0));
    add_row(fc(CMD_UNUSED, 0, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_INIT, 1'b0, P_INIT, 1'b0, 1'b0));
    add_row(fc(mps_pkg::CMD_START, 0, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_ARMED, 1'b1, P_INIT, 1'b0, 1'b0));
    add_row(fc(mps_pkg::CMD_START, 0, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_ARMED, 1'b0, P_ARMED, 1'b0, 1'b1));
    // elapsed exactly at the limit does not trip
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_ARMED, 0, 0, 0, 0, 0), 1'b0, '0);
    // takeoff boundary z*20 vs altitude*19
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, -8388608, 8388607, 9499, 31, 31),
            1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 9500, 0, 0), 1'b0, '0);
    // waypoint counts above the max saturate
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 0, 0, 31), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 0, 17, 0), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 0, 31, 15), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 0, 31, 20), 1'b0, '0);
    // distance exactly on the radius stays in return
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 12000, 0, 0), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 1200, -1600, 10000, 0, 0), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 8001, 0, 0), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 500, 0, 0), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 30100, F_NONE, 0, 0, 499, 0, 0), 1'b0, '0);
    // complete ignores the phase timeout
    add_row(fc(mps_pkg::CMD_UPDATE, 32'hFFFF_FFFF, F_ARMED, 8388607, -8388608, 8388607,
               16, 16), 1'b1,
            pr(P_COMPLETE, 1'b0, P_COMPLETE, 1'b0, 1'b0));
    add_row(fc(mps_pkg::CMD_ABORT, 0, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_RETURN, 1'b1, P_COMPLETE, 1'b0, 1'b0));
    add_row(fc(mps_pkg::CMD_ABORT, 0, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_RETURN, 1'b1, P_RETURN, 1'b0, 1'b0));
    // time wraps, elapsed is one
    add_row(fc(mps_pkg::CMD_UPDATE, 0, F_NONE, -8388608, -8388608, -8388608, 0, 16),
            1'b0, '0);
    add_row(fc(mps_pkg::CMD_START, 0, F_NONE, 0, 0, 0, 0, 0), 1'b1,
            pr(P_RETURN, 1'b0, P_RETURN, 1'b0, 1'b1));
    add_row(fc(mps_pkg::CMD_UPDATE, 29999, F_NONE, 0, 0, 10000, 5, 3), 1'b0, '0);
    add_row(fc(mps_pkg::CMD_UPDATE, 29999, F_NONE, 0, 0, -8388608, 0, 0), 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (flight_plan[i])
      send_item(flight_plan[i].c, flight_plan[i].chk, flight_plan[i].want);
    settle();

    run_random(450, 1'b0);
    settle();
    set_config(32'hFFFF_FFFF, 23'd0, 23'd0);
    run_random(450, 1'b0);
    settle();
    set_config(32'd0, 23'h7F_FFFF, 23'h7F_FFFF);
    run_random(450, 1'b0);
    settle();
    set_config($urandom_range(5000, 100000), 23'($urandom_range(0, 20000)),
               23'($urandom_range(100, 5000)));
    run_random(450, 1'b0);
    settle();
    set_config($urandom_range(1000, 60000), 23'($urandom_range(0, 20000)),
               23'($urandom_range(100, 5000)));
    run_random(250, 1'b1);
    settle();

    $display("%0d commands (%0d from the flight table) under %0d register settings",
             items_sent, flight_plan.size(), settings_used);
    $display("%0d results compared, final phase %0d, failsafe %0d", results_seen, ph_now,
             fs_on);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
